/* rtl/bcv_pkg.sv */
// Constants and curve tables for the battery charge from voltage block.
package bcv_pkg;

  localparam int unsigned VOLT_W    = 17;
  localparam int unsigned CHARGE_W  = 14;
  localparam int unsigned SEG_COUNT = 12;
  localparam int unsigned SEG_W     = 4;
  // quotient within a segment never exceeds the largest step (1000)
  localparam int unsigned Q_W       = 10;

  // steepest segment: 1000 centipercent over 20 mV per cell
  localparam int unsigned MAX_SLOPE = 50;
  localparam int unsigned MAX_SPAN_CELL_MV = 1000;
  localparam int unsigned TOP_CELL_MV = 4200;

  typedef int unsigned seg_tab_t [SEG_COUNT];

  localparam seg_tab_t CELL_LO_MV = '{
    2500, 3500, 3680, 3700, 3730, 3770,
    3790, 3820, 3870, 3930, 4000, 4060
  };
  localparam seg_tab_t CELL_SPAN_MV = '{
    1000, 180, 20, 30, 40, 20,
    30, 50, 60, 70, 60, 140
  };
  localparam seg_tab_t SEG_BASE = '{
    0, 500, 1000, 1500, 2000, 3000,
    4000, 5000, 6000, 7000, 8000, 9000
  };
  localparam seg_tab_t SEG_STEP = '{
    500, 500, 500, 500, 1000, 1000,
    1000, 1000, 1000, 1000, 1000, 1000
  };

endpackage

/* rtl/bcv_front.sv */
// Front end: takes voltage samples, finds the segment and the offset into it.
module bcv_front import bcv_pkg::*; #(
  parameter int unsigned SERIES_CELLS = 6,
  parameter int unsigned D_W = 13
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [VOLT_W-1:0] in_pack_voltage_mv,
  input  logic              q_full,
  output logic              q_push,
  output logic [SEG_W-1:0]  q_seg,
  output logic [D_W-1:0]    q_delta
);

  localparam logic [VOLT_W-1:0] TOP_MV = VOLT_W'(TOP_CELL_MV * SERIES_CELLS);
  localparam logic [D_W-1:0] TOP_SPAN =
    D_W'(CELL_SPAN_MV[SEG_COUNT-1] * SERIES_CELLS);

  logic [SEG_W-1:0]  seg;
  logic [VOLT_W-1:0] seg_lo;
  logic              above;
  logic              below;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    seg    = '0;
    seg_lo = VOLT_W'(CELL_LO_MV[0] * SERIES_CELLS);
    for (int i = 1; i < SEG_COUNT; i++) begin
      if (in_pack_voltage_mv > VOLT_W'(CELL_LO_MV[i] * SERIES_CELLS)) begin
        seg    = SEG_W'(i);
        seg_lo = VOLT_W'(CELL_LO_MV[i] * SERIES_CELLS);
      end
    end
  end

  assign above = in_pack_voltage_mv > TOP_MV;
  assign below = in_pack_voltage_mv <= VOLT_W'(CELL_LO_MV[0] * SERIES_CELLS);

  // Out-of-range samples are pinned to the ends of the curve: zero offset in
  // the first segment, full span in the last one.
  always_comb begin
    q_seg = seg;
    if (above) begin
      q_delta = TOP_SPAN;
    end else if (below) begin
      q_delta = '0;
    end else begin
      q_delta = D_W'(in_pack_voltage_mv - seg_lo);
    end
  end

endmodule

/* rtl/bcv_fifo.sv */
// Two-entry queue between the front end and the interpolation pipeline.
module bcv_fifo #(
  parameter int unsigned W = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full     = count_r == 2'd2;
  assign empty    = count_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

/* rtl/bcv_back.sv */
// Back end: reciprocal multiply, one-step remainder correction, output register.
module bcv_back import bcv_pkg::*; #(
  parameter int unsigned SERIES_CELLS = 6,
  parameter int unsigned D_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [SEG_W-1:0]    q_seg,
  input  logic [D_W-1:0]      q_delta,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHARGE_W-1:0] out_charge_centipercent
);

  // Offset is always below 2**K, so floor(step * 2**K / span) undershoots
  // the quotient by at most one.
  localparam int unsigned K   = D_W;
  localparam int unsigned RW  = $clog2(((MAX_SLOPE << K) / SERIES_CELLS) + 1);
  localparam int unsigned PW  = D_W + RW;
  localparam int unsigned NW  = D_W + Q_W;

  localparam int unsigned SPAN [SEG_COUNT] = '{
    CELL_SPAN_MV[0]  * SERIES_CELLS, CELL_SPAN_MV[1]  * SERIES_CELLS,
    CELL_SPAN_MV[2]  * SERIES_CELLS, CELL_SPAN_MV[3]  * SERIES_CELLS,
    CELL_SPAN_MV[4]  * SERIES_CELLS, CELL_SPAN_MV[5]  * SERIES_CELLS,
    CELL_SPAN_MV[6]  * SERIES_CELLS, CELL_SPAN_MV[7]  * SERIES_CELLS,
    CELL_SPAN_MV[8]  * SERIES_CELLS, CELL_SPAN_MV[9]  * SERIES_CELLS,
    CELL_SPAN_MV[10] * SERIES_CELLS, CELL_SPAN_MV[11] * SERIES_CELLS
  };

  localparam int unsigned RECIP [SEG_COUNT] = '{
    (SEG_STEP[0]  << K) / (CELL_SPAN_MV[0]  * SERIES_CELLS),
    (SEG_STEP[1]  << K) / (CELL_SPAN_MV[1]  * SERIES_CELLS),
    (SEG_STEP[2]  << K) / (CELL_SPAN_MV[2]  * SERIES_CELLS),
    (SEG_STEP[3]  << K) / (CELL_SPAN_MV[3]  * SERIES_CELLS),
    (SEG_STEP[4]  << K) / (CELL_SPAN_MV[4]  * SERIES_CELLS),
    (SEG_STEP[5]  << K) / (CELL_SPAN_MV[5]  * SERIES_CELLS),
    (SEG_STEP[6]  << K) / (CELL_SPAN_MV[6]  * SERIES_CELLS),
    (SEG_STEP[7]  << K) / (CELL_SPAN_MV[7]  * SERIES_CELLS),
    (SEG_STEP[8]  << K) / (CELL_SPAN_MV[8]  * SERIES_CELLS),
    (SEG_STEP[9]  << K) / (CELL_SPAN_MV[9]  * SERIES_CELLS),
    (SEG_STEP[10] << K) / (CELL_SPAN_MV[10] * SERIES_CELLS),
    (SEG_STEP[11] << K) / (CELL_SPAN_MV[11] * SERIES_CELLS)
  };

  localparam logic [CHARGE_W-1:0] CHARGE_FULL = CHARGE_W'(10000);

  logic                advance;
  logic                s1_v_r, s1_v_nxt;
  logic [SEG_W-1:0]    s1_seg_r;
  logic [Q_W-1:0]      s1_q_r;
  logic [NW-1:0]       s1_num_r;
  logic                out_valid_r, out_valid_nxt;
  logic [CHARGE_W-1:0] out_charge_r;

  logic [PW-1:0]       prod;
  logic [NW-1:0]       num;
  logic [D_W-1:0]      s1_span;
  logic [NW-1:0]       qs;
  logic [NW-1:0]       rem;
  logic                inc;
  logic [CHARGE_W-1:0] charge;

  assign advance = !(out_valid_r && out_stall);
  assign q_pop   = advance && !q_empty;

  // stage 1: estimate quotient and form the exact numerator
  assign prod = PW'(q_delta) * PW'(RW'(RECIP[q_seg]));
  assign num  = NW'(q_delta) * NW'(Q_W'(SEG_STEP[q_seg]));

  // stage 2: fix the estimate against the remainder and add the segment base
  assign s1_span = D_W'(SPAN[s1_seg_r]);
  assign qs      = NW'(s1_q_r) * NW'(s1_span);
  assign rem     = s1_num_r - qs;
  assign inc     = rem >= NW'(s1_span);
  assign charge  = CHARGE_W'(SEG_BASE[s1_seg_r]) + CHARGE_W'(s1_q_r)
                 + CHARGE_W'(inc);

  always_comb begin
    s1_v_nxt      = s1_v_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      s1_v_nxt      = !q_empty;
      out_valid_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_seg_r     <= q_seg;
      s1_q_r       <= prod[K +: Q_W];
      s1_num_r     <= num;
      out_charge_r <= charge;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_charge_centipercent = out_charge_r;

  a_one_step_fix: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_num_r >= qs) && (rem < (NW'(s1_span) << 1)))
    else $error("quotient estimate off by more than one");

  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_charge_r <= CHARGE_FULL)
    else $error("charge above full scale");

endmodule

/* rtl/battery_charge_from_voltage_top.sv */
// Top level: pack voltage (mV) to remaining charge (0.01 %) converter.
//
// Input channel in_*: one pack voltage sample per transaction on
// in_pack_voltage_mv, taken when in_valid is high and in_stall is low.
// Output channel out_*: one charge value per sample, in arrival order, on
// out_charge_centipercent, taken when out_valid is high and out_stall low.
// The curve is piecewise linear over twelve per-cell segments scaled by
// SERIES_CELLS; below the bottom breakpoint the charge is 0, above the top
// it is 10000.
// Throughput: one sample per cycle while the receiver does not stall. The
// front end classifies the sample combinationally into a two-entry queue;
// the back end is two registered stages (reciprocal multiply, then
// remainder correction into the output register). A sample passes from the
// queue through the stage-1 registers into the output register.
// Reset clears the queue and all valid flags; the data registers are not reset.
// When the receiver stalls, the output holds and the back end freezes; the
// queue still takes up to two samples before in_stall rises.
module battery_charge_from_voltage_top import bcv_pkg::*; #(
  parameter int unsigned SERIES_CELLS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [VOLT_W-1:0]   in_pack_voltage_mv,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHARGE_W-1:0] out_charge_centipercent
);

  localparam int unsigned D_W = $clog2(MAX_SPAN_CELL_MV * SERIES_CELLS + 1);
  localparam int unsigned EW  = SEG_W + D_W;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [SEG_W-1:0] f_seg;
  logic [D_W-1:0]   f_delta;
  logic [EW-1:0]    q_rd_data;

  bcv_front #(
    .SERIES_CELLS(SERIES_CELLS),
    .D_W(D_W)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pack_voltage_mv(in_pack_voltage_mv),
    .q_full(q_full),
    .q_push(q_push),
    .q_seg(f_seg),
    .q_delta(f_delta)
  );

  bcv_fifo #(
    .W(EW)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data({f_seg, f_delta}),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .pop_data(q_rd_data)
  );

  bcv_back #(
    .SERIES_CELLS(SERIES_CELLS),
    .D_W(D_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_seg(q_rd_data[EW-1 -: SEG_W]),
    .q_delta(q_rd_data[D_W-1:0]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_charge_centipercent(out_charge_centipercent)
  );

endmodule

/* tb/battery_charge_from_voltage_top_test.sv */
// Testbench for the pack voltage to remaining charge converter.
`timescale 1ns / 100ps

module battery_charge_from_voltage_top_test;

  localparam int VW    = bcv_pkg::VOLT_W;
  localparam int CW    = bcv_pkg::CHARGE_W;
  localparam int CELLS = 6;
  localparam int RANDOM_SAMPLES = 850;
  localparam int FULL_CHARGE = 10000;
  localparam int PREDICT = -1;

  // per-cell knees of the discharge curve, and per-segment base and step
  localparam int unsigned KNEE_MV [13] = '{
    2500, 3500, 3680, 3700, 3730, 3770, 3790,
    3820, 3870, 3930, 4000, 4060, 4200
  };
  localparam int unsigned BASE_CP [12] = '{
    0, 500, 1000, 1500, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000
  };
  localparam int unsigned STEP_CP [12] = '{
    500, 500, 500, 500, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000
  };
  localparam int unsigned IDLE_LEVELS [4] = '{0, 20, 60, 100};

  localparam int DIR_COUNT = 25;
  localparam int DIR_VOLT [DIR_COUNT] = '{
    0, 131071, 1, 65536, 15000, 15001, 21000, 22080, 22200, 22380,
    22620, 22740, 22920, 23220, 23580, 24000, 24360, 25200, 25201,
    18000, 21001, 22100, 22500, 23000, 25199
  };
  localparam int DIR_WANT [DIR_COUNT] = '{
    0, FULL_CHARGE, 0, FULL_CHARGE, 0, 0, 500, 1000, 1500, 2000,
    3000, 4000, 5000, 6000, 7000, 8000, 9000, FULL_CHARGE, FULL_CHARGE,
    PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] in_pack_voltage_mv = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [CW-1:0] out_charge_centipercent;

  logic [CW-1:0] expected_charges [$];
  int mismatch_count = 0;
  int checked_count = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int send_idle_pct = 30;
  int take_stall_pct = 30;

  battery_charge_from_voltage_top #(
    .SERIES_CELLS(CELLS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pack_voltage_mv(in_pack_voltage_mv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_charge_centipercent(out_charge_centipercent)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // piecewise linear curve; a voltage on a knee belongs to the lower segment
  function automatic logic [CW-1:0] charge_for_voltage(input logic [VW-1:0] volt);
    int unsigned v;
    int unsigned lo;
    int unsigned span;
    v = 32'(volt);
    if (v > KNEE_MV[12] * CELLS) return CW'(FULL_CHARGE);
    for (int s = 11; s >= 0; s--) begin
      lo = KNEE_MV[s] * CELLS;
      if (v > lo) begin
        span = (KNEE_MV[s+1] - KNEE_MV[s]) * CELLS;
        return CW'(BASE_CP[s] + (STEP_CP[s] * (v - lo)) / span);
      end
    end
    return '0;
  endfunction

  function automatic logic [VW-1:0] random_pack_voltage();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 50) return VW'($urandom_range(CELLS * KNEE_MV[12], CELLS * KNEE_MV[0]));
    if (pick < 78) begin
      k = $urandom_range(12);
      return VW'(CELLS * KNEE_MV[k] + $urandom_range(6) - 3);
    end
    return VW'($urandom);
  endfunction

  task automatic send_sample(input logic [VW-1:0] volt, input logic [CW-1:0] charge);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pack_voltage_mv <= volt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_charges.push_back(charge);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_charges.size() != 0) @(posedge clk);
  endtask

  // receiver: stall for a random number of cycles before each transaction
  initial begin : result_taker
    int hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = ($urandom_range(99) < take_stall_pct) ? $urandom_range(14) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (out_charge_centipercent == CW'(FULL_CHARGE)) full_seen++;
      if (out_charge_centipercent == '0) empty_seen++;
      if (expected_charges.size() == 0) begin
        mismatch_count++;
        $display("%0t: charge %0d with none expected", $time, out_charge_centipercent);
      end else begin
        if (out_charge_centipercent != expected_charges[0]) begin
          mismatch_count++;
          $display("%0t: charge expected %0d, actual %0d", $time, expected_charges[0],
                   out_charge_centipercent);
        end
        void'(expected_charges.pop_front());
      end
    end
  end

  initial begin : stimulus
    logic [VW-1:0] volt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_COUNT; i++) begin
      volt = VW'(DIR_VOLT[i]);
      send_sample(volt, (DIR_WANT[i] == PREDICT) ? charge_for_voltage(volt)
                                                  : CW'(DIR_WANT[i]));
    end
    drain_results();

    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      if (i % 100 == 0) begin
        send_idle_pct = IDLE_LEVELS[$urandom_range(3)];
        take_stall_pct = IDLE_LEVELS[$urandom_range(3)];
      end
      // sender holds off until the pipeline is empty
      if (i == RANDOM_SAMPLES / 2) drain_results();
      volt = random_pack_voltage();
      send_sample(volt, charge_for_voltage(volt));
    end
    in_valid <= 1'b0;

    while (expected_charges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d charge transactions: %0d directed, %0d random voltages.",
             checked_count, DIR_COUNT, RANDOM_SAMPLES);
    $display("Full scale hit %0d times, empty %0d times.", full_seen, empty_seen);
    if (mismatch_count == 0 && expected_charges.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bcv_pkg.sv
rtl/bcv_front.sv
rtl/bcv_fifo.sv
rtl/bcv_back.sv
rtl/battery_charge_from_voltage_top.sv
tb/battery_charge_from_voltage_top_test.sv
